// ===== hdl/csp_pkg.sv =====
package csp_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // field widths
    localparam int CMD_W    = 2;
    localparam int VAL_W    = 32;
    localparam int SUB_W    = 6;
    localparam int HEIGHT_W = 7;
    localparam int STATUS_W = 2;

    // substack index times height, plus one height, fits here
    localparam int PROD_W = SUB_W + HEIGHT_W + 1;

    // height limits
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(5);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(64);

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSUB = 2'd3;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // cell at pos takes the pushed value
        logic shift;  // cells at and above pos take their upper neighbor
    } t_cell_op;

endpackage

// ===== hdl/csp_cell.sv =====
module csp_cell #(
    parameter int DATA_WIDTH = csp_pkg::DATA_WIDTH_DEF,
    parameter int AW         = 6,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  csp_pkg::t_cell_op     i_op,
    input  logic [AW-1:0]         i_pos,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_upper_data,
    output logic [DATA_WIDTH-1:0] o_data
);
    import csp_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  w_here;
    logic                  w_above;

    // position compare against the broadcast address
    assign w_here  = (i_pos == AW'(IDX));
    assign w_above = (i_pos <= AW'(IDX));

    // entry storage: load on push, take neighbor on removal
    always_ff @(posedge i_clk) begin
        if (i_op.load && w_here) begin
            r_data <= i_push_data;
        end else if (i_op.shift && w_above) begin
            r_data <= i_upper_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hdl/chunked_stack_with_pop_at.sv =====
// Chunked stack with pop-at: one stack of DEPTH entries seen as substacks
// of a programmable height, substack 0 at the bottom.
// Command channel: drive i_cmd, i_push_value and i_substack_index with
// start high; the command is taken at a clock edge where busy is low.
// Each command gives exactly one result on o_out_value / o_status, shown
// for one cycle with o_done high; the receiver cannot stall it.
// Timing: a command is taken in the idle state, the substack product is formed in
// the calc state, the cell chain updates in the execute state and the result is
// shown in the cycle after that, where the next command can already be taken.
// No new command is taken while busy, through the multiply stage and the update.
// Pop-at moves every entry above the removed one down one cell at the same
// clock edge, each cell taking its upper neighbor.
// Height register: i_cfg_we with i_cfg_wdata, to be written only while idle
// (the block itself does not enforce this); 0 acts as 1 and above 64 as 64.
// Reset (synchronous, active low) empties the stack and sets the height
// to 5; entry contents are not cleared.
module chunked_stack_with_pop_at #(
    parameter int DEPTH      = csp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = csp_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [csp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [csp_pkg::VAL_W-1:0]      i_push_value,
    input  logic [csp_pkg::SUB_W-1:0]      i_substack_index,
    input  logic                           i_cfg_we,
    input  logic [csp_pkg::HEIGHT_W-1:0]   i_cfg_wdata,
    output logic                           o_done,
    output logic [csp_pkg::VAL_W-1:0]      o_out_value,
    output logic [csp_pkg::STATUS_W-1:0]   o_status
);
    import csp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic [SUB_W-1:0]      r_k;
    logic [PROD_W-1:0]     r_kh;
    logic [CW-1:0]         r_count;
    logic [HEIGHT_W-1:0]   r_height;
    logic [DATA_WIDTH-1:0] r_out;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_done;

    logic [HEIGHT_W-1:0]   w_h;
    logic [PROD_W-1:0]     w_end;
    logic [PROD_W-1:0]     w_cnt;
    logic                  w_is_top;
    logic                  w_empty;
    t_cell_op              w_op;
    logic [AW-1:0]         w_pos;
    logic [STATUS_W-1:0]   w_status;
    logic                  w_take;
    logic [DATA_WIDTH-1:0] w_cell [DEPTH];

    // effective height, clamped to 1..64
    always_comb begin
        if (r_height == '0) begin
            w_h = HEIGHT_W'(1);
        end else if (r_height > HEIGHT_MAX) begin
            w_h = HEIGHT_MAX;
        end else begin
            w_h = r_height;
        end
    end

    // substack bounds: r_kh is its first entry, w_end one past its last
    assign w_end   = r_kh + PROD_W'(w_h);
    assign w_cnt   = PROD_W'(r_count);
    assign w_empty = (r_count == '0);
    assign w_is_top = w_empty ? (r_k == '0) : ((r_kh < w_cnt) && (w_end >= w_cnt));

    // command decode in the execute cycle
    always_comb begin
        w_op     = '0;
        w_pos    = '0;
        w_status = ST_OK;
        w_take   = 1'b0;
        if (r_state == S_EXEC) begin
            unique case (r_cmd)
                CMD_PUSH: begin
                    if (r_count == CW'(DEPTH)) begin
                        w_status = ST_FULL;
                    end else begin
                        w_op.load = 1'b1;
                        w_pos     = AW'(r_count);
                    end
                end
                CMD_POP, CMD_POP_AT: begin
                    if (r_cmd == CMD_POP || w_is_top) begin
                        if (w_empty) begin
                            w_status = ST_EMPTY;
                        end else begin
                            w_op.shift = 1'b1;
                            w_take     = 1'b1;
                            w_pos      = AW'(r_count - CW'(1));
                        end
                    end else if (w_empty || (r_kh >= w_cnt)) begin
                        w_status = ST_NOSUB;
                    end else begin
                        w_op.shift = 1'b1;
                        w_take     = 1'b1;
                        w_pos      = AW'(w_end - PROD_W'(1));
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
        end
    end

    // chain of entry cells, each fed by its upper neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_upper;
        if (g == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid
            assign w_upper = w_cell[g+1];
        end
        csp_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .AW         (AW),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_pos        (w_pos),
            .i_push_data  (r_val),
            .i_upper_data (w_upper),
            .o_data       (w_cell[g])
        );
    end

    // sequencer, count, height register and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_height <= HEIGHT_RST;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_out    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_height <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_status <= w_status;
                    r_out    <= w_take ? w_cell[w_pos] : '0;
                    if (w_op.load) begin
                        r_count <= r_count + CW'(1);
                    end else if (w_op.shift) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
            r_val <= DATA_WIDTH'(i_push_value);
            r_k   <= i_substack_index;
        end
        if (r_state == S_CALC) begin
            r_kh <= PROD_W'(r_k) * PROD_W'(w_h);
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_value = VAL_W'(r_out);

endmodule

// ===== bench/chunked_stack_with_pop_at_test.sv =====
`timescale 1ns / 1ps

module chunked_stack_with_pop_at_test;
    import csp_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES = 10;
    // command code left unused by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0] op;
        logic [VAL_W-1:0] value;
        logic [SUB_W-1:0] sub;
    } t_stack_cmd;

    typedef struct {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } t_stack_result;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd = CMD_PUSH;
    logic [VAL_W-1:0]    i_push_value = '0;
    logic [SUB_W-1:0]    i_substack_index = '0;
    logic                i_cfg_we = 1'b0;
    logic [HEIGHT_W-1:0] i_cfg_wdata = '0;
    logic                o_done;
    logic [VAL_W-1:0]    o_out_value;
    logic [STATUS_W-1:0] o_status;

    t_stack_cmd    cmd_q[$];
    t_stack_result result_q[$];
    int            errors = 0;
    int            idle_cycles = 0;
    logic          took_cmd = 1'b0;

    // mirror of the stack contents and height register
    logic [VAL_W-1:0]    stack_mem [STACK_DEPTH];
    int unsigned         fill_count = 0;
    logic [HEIGHT_W-1:0] height_cfg = HEIGHT_RST;

    // sender burst pacing
    int   burst_left = 1;
    int   gap_left = 0;
    logic drain_hold = 1'b0;

    chunked_stack_with_pop_at dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_push_value     (i_push_value),
        .i_substack_index (i_substack_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_out_value      (o_out_value),
        .o_status         (o_status)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // height as the block uses it: 0 acts as 1, above 64 acts as 64
    function automatic int unsigned eff_height();
        if (height_cfg == 0) return 1;
        if (height_cfg > HEIGHT_MAX) return HEIGHT_MAX;
        return height_cfg;
    endfunction

    // take out one entry and close the hole
    function automatic logic [VAL_W-1:0] remove_entry(input int unsigned pos);
        logic [VAL_W-1:0] v;
        v = stack_mem[pos];
        for (int unsigned i = pos; i + 1 < fill_count; i++) begin
            stack_mem[i] = stack_mem[i + 1];
        end
        fill_count--;
        return v;
    endfunction

    // expected result of one command, updating the mirror
    function automatic t_stack_result stack_outcome(input t_stack_cmd c);
        t_stack_result r;
        int unsigned   h;
        int unsigned   top_sub;
        int unsigned   pos;
        h = eff_height();
        top_sub = (fill_count == 0) ? 0 : (fill_count - 1) / h;
        r.value = '0;
        r.status = ST_OK;
        if (c.op == CMD_PUSH) begin
            if (fill_count >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                stack_mem[fill_count] = c.value;
                fill_count++;
            end
        end else if (c.op == CMD_POP || (c.op == CMD_POP_AT && c.sub == top_sub)) begin
            if (fill_count == 0) r.status = ST_EMPTY;
            else r.value = remove_entry(fill_count - 1);
        end else if (c.op == CMD_POP_AT) begin
            pos = (c.sub + 1) * h - 1;
            if (c.sub > top_sub || pos >= fill_count) r.status = ST_NOSUB;
            else r.value = remove_entry(pos);
        end
        return r;
    endfunction

    function automatic t_stack_cmd stack_cmd(input logic [CMD_W-1:0] op,
                                             input logic [VAL_W-1:0] value,
                                             input logic [SUB_W-1:0] sub);
        t_stack_cmd c;
        c.op = op;
        c.value = value;
        c.sub = sub;
        return c;
    endfunction

    // random command, push-heavy or pop-heavy
    function automatic t_stack_cmd random_cmd(input bit push_heavy);
        t_stack_cmd  c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) c.op = CMD_UNUSED;
        else if (roll < (push_heavy ? 75 : 35)) c.op = CMD_PUSH;
        else if (roll < (push_heavy ? 87 : 65)) c.op = CMD_POP;
        else c.op = CMD_POP_AT;
        roll = $urandom_range(0, 9);
        c.value = (roll == 0) ? '0 : (roll == 1) ? '1 : VAL_W'($urandom);
        if ($urandom_range(0, 9) < 7) c.sub = SUB_W'($urandom_range(0, 64 / eff_height()));
        else c.sub = SUB_W'($urandom_range(0, 63));
        return c;
    endfunction

    // driver: bursts of commands with random gaps, some gaps wait for a full drain
    always @(negedge i_clk) begin : driver
        t_stack_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_cmd) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (drain_hold && result_q.size() != 0) begin
                start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                c = cmd_q[0];
                cmd_q.delete(0);
                i_cmd <= c.op;
                i_push_value <= c.value;
                i_substack_index <= c.sub;
                start <= 1'b1;
                drain_hold = 1'b0;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    drain_hold = ($urandom_range(0, 15) == 0);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, predict accepted commands, watchdog
    always @(posedge i_clk) begin : monitor
        t_stack_result got;
        t_stack_result want;
        if (!i_rst_n) begin
            took_cmd <= 1'b0;
        end else begin
            if (o_done === 1'b1) begin
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value %h status %0d",
                             $time, o_out_value, o_status);
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (o_out_value !== want.value) begin
                        errors++;
                        $display("%0t: out_value expected %h actual %h",
                                 $time, want.value, o_out_value);
                    end
                    if (o_status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                    end
                end
            end
            // command transfer
            if (start && !busy) begin
                got = stack_outcome(stack_cmd(i_cmd, i_push_value, i_substack_index));
                result_q.push_back(got);
            end
            took_cmd <= start && !busy;
            if ((start && !busy) || o_done === 1'b1) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: timeout", $time);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // wait until every command is taken and every result has come
    task automatic wait_drained();
        while (cmd_q.size() != 0 || result_q.size() != 0 || start) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_height(input logic [HEIGHT_W-1:0] h);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= h;
        height_cfg = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
    endtask

    initial begin
        logic [HEIGHT_W-1:0] h;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, extremes, folding of the top substack, height 5
        cmd_q.push_back(stack_cmd(CMD_POP, '0, '0));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd0));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd63));
        cmd_q.push_back(stack_cmd(CMD_UNUSED, '0, '0));
        cmd_q.push_back(stack_cmd(CMD_PUSH, 32'hFFFF_FFFF, '0));
        cmd_q.push_back(stack_cmd(CMD_PUSH, 32'h0000_0000, '1));
        for (int i = 0; i < 6; i++) begin
            cmd_q.push_back(stack_cmd(CMD_PUSH, 32'h1111_1111 * (i + 2), '0));
        end
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd1));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd2));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd0));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd0));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd1));
        cmd_q.push_back(stack_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63));
        cmd_q.push_back(stack_cmd(CMD_POP, 32'hFFFF_FFFF, 6'd63));
        cmd_q.push_back(stack_cmd(CMD_PUSH, 32'h5A5A_5A5A, '0));
        cmd_q.push_back(stack_cmd(CMD_POP_AT, '0, 6'd0));
        wait_drained();

        // random phases over several heights, entries kept across height changes
        for (int p = 0; p < NUM_PHASES; p++) begin
            unique case (p)
                0: h = 7'd1;
                1: h = 7'd64;
                2: h = 7'd0;
                3: h = 7'd127;
                4: h = 7'd2;
                5: h = 7'd5;
                6: h = 7'd13;
                7: h = 7'd33;
                8: h = HEIGHT_W'($urandom_range(1, 64));
                default: h = HEIGHT_W'($urandom_range(0, 127));
            endcase
            write_height(h);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                cmd_q.push_back(random_cmd(i < ITEMS_PER_PHASE / 2));
            end
            wait_drained();
        end

        if (errors == 0 && result_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
